>>> sv/rtt_pkg.sv
// rtt_pkg: widths, constants and register codes of the raster to tiled texture unit.
// Depends on nothing; used by the stream interfaces and the top level.
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int PIX_W      = 24;
  localparam int WORD_W     = 32;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WIDX_W     = 4;

  // Stream bytes and alpha fill
  localparam logic [7:0]        ALPHA_BYTE = 8'hFF;
  localparam logic [WORD_W-1:0] HALF_ALPHA = 32'h8000_8000;

  // Pixel modes
  localparam logic MODE_RGB5A3 = 1'b0;
  localparam logic MODE_RGBA8  = 1'b1;

  // Index of the last word of a tile in each mode
  localparam logic [WIDX_W-1:0] LAST_RGBA8  = 4'd15;
  localparam logic [WIDX_W-1:0] LAST_RGB5A3 = 4'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

endpackage

>>> sv/rtt_stream_if.sv
// rtt_stream_if: valid/ready channels for source pixels and texture words.
// Depends on rtt_pkg for the payload widths.
`timescale 1ns / 1ps

interface rtt_pixel_if import rtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface rtt_texel_if import rtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] texel_word;
  logic              tile_last;

  modport source (output valid, output texel_word, output tile_last, input ready);
  modport sink   (input valid, input texel_word, input tile_last, output ready);
endinterface

>>> sv/rtt_ram.sv
// rtt_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rtt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write the entry; read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/raster_to_tiled_texture_unit.sv
// raster_to_tiled_texture_unit: raster pixels in, 4x4 tiled texture words out.
// Depends on rtt_pkg, rtt_stream_if (rtt_pixel_if, rtt_texel_if) and rtt_ram.
`timescale 1ns / 1ps

// Pixels arrive in raster order, one per cycle while the input is ready, and land in a four-row line store
// split into an even-column bank and an odd-column bank, so one read of both banks
// yields the two pixels of one output word. When the bottom-right pixel of a
// complete tile is taken, the tile is read out at one word per cycle: 16 words in
// RGBA8 mode (alpha/red pairs, then green/blue pairs), 8 words in RGB5A3 mode.
// The input keeps flowing during a burst except for a pixel that completes the next
// tile or that would write into the four columns being read; those wait until the
// cycle after the burst's last read. Output backpressure stalls the read pipeline and
// then the input. The line store needs no clearing pass; entries are only read after
// being written.
module raster_to_tiled_texture_unit import rtt_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtt_pixel_if.sink             in_px,
  rtt_texel_if.source           out_tx,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int BANK_DEPTH = 4 * HALF_W;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam logic [12:0] MAX_W_L = 13'(MAX_WIDTH);
  localparam logic [12:0] MAX_H_L = 13'(MAX_HEIGHT);

  // Configuration registers
  logic             pixel_mode_r;
  logic [COL_W-1:0] frame_width_r;
  logic [ROW_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r   <= MODE_RGB5A3;
      frame_width_r  <= '0;
      frame_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_MODE:   pixel_mode_r   <= cfg_data[0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[COL_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [COL_W-1:0] c_start, c_cur, c_inc;
  logic [ROW_W-1:0] r_start, r_wrap, r_cur, r_adv, r_end;
  logic             size_zero, wrap_pre, wrap_post;
  logic [12:0]      w_cap, h_cap, tile_w, tile_h;
  logic             trig, do_store, conflict;

  // Emitter control
  logic                    busy_r, busy_nxt;
  logic [WIDX_W-1:0]       k_r, k_nxt;
  logic [COL_W-3:0]        tile_grp_r;
  logic [WIDX_W-1:0]       last_k;
  logic                    in_acc, rd_en, adv;
  logic                    rdv_r, rdv_nxt;
  logic [WIDX_W-1:0]       rk_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]       out_word_r;
  logic                    out_last_r;

  // Line store ports
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_even, wr_odd;
  logic [PIX_W-1:0] pix_a, pix_b;
  logic [WORD_W-1:0] word_fmt;

  // Position of this pixel and of the next one
  always_comb begin
    c_start   = in_px.frame_start ? '0 : col_r;
    r_start   = in_px.frame_start ? '0 : row_r;
    size_zero = (frame_width_r == '0) || (frame_height_r == '0);
    wrap_pre  = (c_start >= frame_width_r);
    c_cur     = wrap_pre ? '0 : c_start;
    r_wrap    = wrap_pre ? r_start + 1'b1 : r_start;
    r_cur     = (r_wrap >= frame_height_r) ? '0 : r_wrap;
    c_inc     = c_cur + 1'b1;
    wrap_post = (c_inc >= frame_width_r);
    r_adv     = wrap_post ? r_cur + 1'b1 : r_cur;
    r_end     = (r_adv >= frame_height_r) ? '0 : r_adv;
    if (size_zero) begin
      col_nxt = c_start;
      row_nxt = r_start;
    end else begin
      col_nxt = wrap_post ? '0 : c_inc;
      row_nxt = r_end;
    end
  end

  // Convertible area: size clipped to the store, rounded down to four
  always_comb begin
    w_cap  = ({2'b00, frame_width_r} < MAX_W_L) ? {2'b00, frame_width_r} : MAX_W_L;
    h_cap  = ({3'b000, frame_height_r} < MAX_H_L) ? {3'b000, frame_height_r} : MAX_H_L;
    tile_w = w_cap & ~13'd3;
    tile_h = h_cap & ~13'd3;
  end

  assign trig = !size_zero && (c_cur[1:0] == 2'd3) && (r_cur[1:0] == 2'd3)
              && ({2'b00, c_cur} < tile_w) && ({3'b000, r_cur} < tile_h);
  assign do_store = !size_zero && ({2'b00, c_cur} < MAX_W_L);
  assign conflict = busy_r && (c_cur[COL_W-1:2] == tile_grp_r);

  // Hold a pixel that completes a tile or writes into the tile under readout
  assign in_px.ready = !busy_r || (!trig && !conflict);
  assign in_acc      = in_px.valid && in_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Store the pixel in its column bank
  assign wr_addr = AW'(int'(r_cur[1:0]) * HALF_W + int'(c_cur[COL_W-1:1]));
  assign wr_even = in_acc && do_store && !c_cur[0];
  assign wr_odd  = in_acc && do_store && c_cur[0];

  // Issue one bank-pair read per word while the downstream has room
  assign last_k  = (pixel_mode_r == MODE_RGBA8) ? LAST_RGBA8 : LAST_RGB5A3;
  assign adv     = rdv_r && (!out_valid_r || out_tx.ready);
  assign rd_en   = busy_r && (!rdv_r || adv);
  assign rd_addr = AW'(int'(k_r[2:1]) * HALF_W + int'(tile_grp_r) * 2 + int'(k_r[0]));

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (rd_en) begin
      k_nxt = k_r + 1'b1;
      if (k_r == last_k) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_acc && trig) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && trig) begin
      tile_grp_r <= c_cur[COL_W-1:2];
    end
  end

  rtt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_addr),
    .wr_data (in_px.pixel_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pix_a)
  );

  rtt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_addr),
    .wr_data (in_px.pixel_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pix_b)
  );

  // Track the word index that sits on the bank outputs
  always_comb begin
    rdv_nxt = rdv_r;
    if (rd_en) begin
      rdv_nxt = 1'b1;
    end else if (adv) begin
      rdv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rk_r <= k_r;
    end
  end

  // Pack the pixel pair into one stream word
  always_comb begin
    if (pixel_mode_r == MODE_RGBA8) begin
      if (!rk_r[3]) begin
        word_fmt = {ALPHA_BYTE, pix_a[23:16], ALPHA_BYTE, pix_b[23:16]};
      end else begin
        word_fmt = {pix_a[15:0], pix_b[15:0]};
      end
    end else begin
      word_fmt = {pix_a[15:0], pix_b[15:0]} | HALF_ALPHA;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tx.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= word_fmt;
      out_last_r <= (rk_r == last_k);
    end
  end

  assign out_tx.valid      = out_valid_r;
  assign out_tx.texel_word = out_word_r;
  assign out_tx.tile_last  = out_last_r;

`ifndef SYNTHESIS
  // The burst ends right after its last read
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && (k_r == last_k) && !(in_acc && trig)) |=> !busy_r)
    else $error("tile readout did not stop after its last word");

  // No pixel lands in the columns of the tile under readout
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (wr_even || wr_odd)) |-> (c_cur[COL_W-1:2] != tile_grp_r))
    else $error("line store write into the tile being read");

  // A burst only starts from an accepted tile-completing pixel
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(in_acc && trig))
    else $error("tile readout started without a completing pixel");

  // Bank outputs hold their word while the output register is full
  a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rdv_r && !adv) |=> (rdv_r && $stable(rk_r)))
    else $error("bank output word lost under backpressure");
`endif

endmodule

>>> test/raster_to_tiled_texture_unit_tb.sv
// raster_to_tiled_texture_unit_tb: self-checking bench for the raster to tiled texture unit.
// Drives pixel requests and register writes, predicts tile words in a scoreboard class.
// Depends on rtt_pkg, rtt_stream_if and raster_to_tiled_texture_unit.
`timescale 1ns / 1ps

module raster_to_tiled_texture_unit_tb import rtt_pkg::*;;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 512;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SMALL_ITEMS  = 450;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } texel_t;

  // Tile predictor: line store, counters and registers, plus the queue of words to come
  class texel_scoreboard #(int MAX_W = 1024, int MAX_H = 512);
    logic [PIX_W-1:0] line_store [4*MAX_W];
    int unsigned      col, row, width, height;
    logic             mode;
    texel_t           tile_words_q[$];
    int               errors;

    function new();
      col    = 0;
      row    = 0;
      width  = 0;
      height = 0;
      mode   = MODE_RGB5A3;
      errors = 0;
    endfunction

    function int pending();
      return tile_words_q.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PIXEL_MODE:   mode   = val[0];
        CFG_FRAME_WIDTH:  width  = 32'(val);
        CFG_FRAME_HEIGHT: height = 32'(val[ROW_W-1:0]);
        default: ;
      endcase
    endfunction

    // Store one accepted pixel and queue the tile it completes, if any
    function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
      int unsigned      cw, ch, words, base;
      logic [PIX_W-1:0] a, b;
      texel_t           t;
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (width == 0 || height == 0) return;
      if (col >= width) begin
        col = 0;
        row++;
      end
      if (row >= height) row = 0;
      if (col < MAX_W) line_store[(row & 3) * MAX_W + col] = pix;

      cw = ((width < MAX_W) ? width : MAX_W) & ~32'd3;
      ch = ((height < MAX_H) ? height : MAX_H) & ~32'd3;
      if ((col & 3) == 3 && (row & 3) == 3 && col < cw && row < ch) begin
        words = (mode == MODE_RGBA8) ? 16 : 8;
        for (int k = 0; k < words; k++) begin
          // two words per tile row, each word a pair of adjacent pixels
          base = ((k % 8) / 2) * MAX_W + col - 3 + (k % 2) * 2;
          a = line_store[base];
          b = line_store[base + 1];
          if (mode == MODE_RGBA8 && k < 8)
            t.word = {ALPHA_BYTE, a[23:16], ALPHA_BYTE, b[23:16]};
          else if (mode == MODE_RGBA8)
            t.word = {a[15:0], b[15:0]};
          else
            t.word = {a[15:0], b[15:0]} | HALF_ALPHA;
          t.last = (k == words - 1);
          tile_words_q.push_back(t);
        end
      end

      col++;
      if (col >= width) begin
        col = 0;
        row++;
        if (row >= height) row = 0;
      end
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one accepted word with the oldest queued prediction
    task check_word(logic [WORD_W-1:0] word, logic last);
      texel_t t;
      if (tile_words_q.size() == 0) begin
        report($sformatf("unexpected texel_word %h tile_last %b", word, last));
        return;
      end
      t = tile_words_q.pop_front();
      if (word !== t.word)
        report($sformatf("texel_word %h, predicted %h", word, t.word));
      if (last !== t.last)
        report($sformatf("tile_last %b, predicted %b (word %h)", last, t.last, t.word));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rtt_pixel_if px_if ();
  rtt_texel_if tx_if ();

  texel_scoreboard #(MAX_WIDTH, MAX_HEIGHT) sb;

  int gap_pct;
  int stall_pct;
  int hold_requests;
  int cycle_count;

  raster_to_tiled_texture_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (px_if),
    .out_tx    (tx_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Sample accepted requests on both channels
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (px_if.valid && px_if.ready) sb.note_pixel(px_if.pixel_value, px_if.frame_start);
      if (tx_if.valid && tx_if.ready) sb.check_word(tx_if.texel_word, tx_if.tile_last);
    end
  end

  // Drive output ready: random stalls, or a long hold when one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    tx_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_if.ready <= 1'b0;
      end else begin
        tx_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one pixel request after random gaps and hold it until accepted
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    while ($urandom_range(99) < gap_pct) begin
      px_if.valid <= 1'b0;
      @(negedge clk);
    end
    px_if.valid       <= 1'b1;
    px_if.pixel_value <= pix;
    px_if.frame_start <= fs;
    do @(posedge clk); while (px_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and wait for every predicted word to arrive
  task automatic wait_drained();
    px_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Write all three registers on consecutive cycles; only called while idle
  task automatic program_regs(logic m, int w, int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PIXEL_MODE;
    cfg_data  <= CFG_DATA_W'(m);
    sb.write_reg(CFG_PIXEL_MODE, CFG_DATA_W'(m));
    @(negedge clk);
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    sb.write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    @(negedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    sb.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int               p, n, w, h, k, frame, small_items, prev_w, prev_h;
    logic             m;
    bit               cont, fs;
    logic [PIX_W-1:0] corner [4];

    corner = '{24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555};
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PIXEL_MODE;
    cfg_data          = '0;
    px_if.valid       = 1'b0;
    px_if.pixel_value = '0;
    px_if.frame_start = 1'b0;
    gap_pct           = 0;
    stall_pct         = 0;
    hold_requests     = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one RGBA8 tile with extreme pixels, then zero width and zero height
    program_regs(MODE_RGBA8, 4, 4);
    for (k = 0; k < 16; k++)
      send_pixel((k < 4) ? corner[k] : ((k < 8) ? ~corner[k - 4] : PIX_W'($urandom())), k == 0);
    settle();
    program_regs(MODE_RGBA8, 0, 4);
    for (k = 0; k < 3; k++) send_pixel(PIX_W'($urandom()), k == 1);
    settle();
    program_regs(MODE_RGB5A3, 4, 0);
    for (k = 0; k < 3; k++) send_pixel(PIX_W'($urandom()), k == 1);

    // Random phases: mostly whole frames, a few fixed sizes, some noise
    small_items = 0;
    prev_w      = 4;
    prev_h      = 0;
    p           = 0;
    while (small_items < SMALL_ITEMS || p < 8) begin
      gap_pct   = (p % 4 == 1) ? 64 : ((p % 4 == 3) ? 21 : 0);
      stall_pct = (p % 4 == 2) ? 64 : ((p % 4 == 3) ? 21 : 0);
      cont      = 1'b0;
      case (p)
        2: begin
          m = MODE_RGBA8;  w = 12;   h = 4;   n = 12 * 4 + 8;
        end
        4: begin
          m = MODE_RGBA8;  w = 8;    h = 8;   n = 8 * 8 + 8;
        end
        5: begin
          m = MODE_RGB5A3; w = 4;    h = 8;   n = 4 * 8 + 8;
        end
        7: begin
          m = MODE_RGBA8;  w = 10;   h = 5;   n = 10 * 5 + 4;
        end
        default: begin
          m = $urandom_range(1, 0);
          w = $urandom_range(12, 1);
          h = $urandom_range(8, 1);
          if ($urandom_range(11) == 0) begin
            if ($urandom_range(1)) w = 0;
            else h = 0;
          end
          // keep streaming without a frame start only when the width does not grow
          cont = prev_w > 0 && prev_h > 0 && w > 0 && h > 0 && w <= prev_w &&
                 $urandom_range(1);
          n = (w == 0 || h == 0) ? 6 : w * h * $urandom_range(2, 1) + $urandom_range(w, 0);
        end
      endcase

      settle();
      program_regs(m, w, h);
      if (p == 4) hold_requests++;

      frame = w * h;
      for (k = 0; k < n; k++) begin
        if (p == 6 && k == n / 2) wait_drained();
        if (frame == 0) fs = (k == 0);
        else fs = !cont && (k % frame == 0);
        if ($urandom_range(99) < 2) fs = 1'b1;
        send_pixel(PIX_W'($urandom()), fs);
      end

      if (w > 0 && h > 0) small_items += n;
      prev_w = w;
      prev_h = h;
      p++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
